>>> rtl/core/sha1_pkg.sv
package sha1_pkg;

  localparam int BlockBytes = 64;
  localparam int LenPos     = 56;
  localparam int DigestWords = 5;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
  } sha1_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        error;
  } sha1_rsp_t;

  // round constant by round number
  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20)      k = K0;
    else if (t < 7'd40) k = K1;
    else if (t < 7'd60) k = K2;
    else                k = K3;
    return k;
  endfunction

  // round function by round number
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20)      f = (b & c) | (~b & d);
    else if (t < 7'd40) f = b ^ c ^ d;
    else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

endpackage

>>> rtl/core/sha1_req_if.sv
interface sha1_req_if;
  logic valid;
  logic ready;
  sha1_pkg::sha1_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/sha1_rsp_if.sv
interface sha1_rsp_if;
  logic valid;
  logic ready;
  sha1_pkg::sha1_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/sha1_ram.sv
module sha1_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/sha1_stream_hasher_core.sv
// SHA-1 engine fed one message byte per word on the request channel. Bytes are
// gathered into 32-bit words, and every fourth byte writes its word into a 16-entry
// block memory as it is accepted. When the 64th byte of a block lands, the engine
// stalls while it runs the rounds, one round per cycle: the first 16 rounds read the
// message words from the block memory, the rest take the expanded schedule from a
// 16-word register window. A fold state then adds in the chaining words. A finish
// word writes the padding one 32-bit word per cycle and runs the compression: the
// first digest word is registered in the fold state of the last block, after a
// second padding and compression pass when the padding spills into a second block.
// The five digest words then leave through an output register, one per cycle
// without back-pressure, index 0 first; a message whose bit count overflowed yields
// one error word the cycle after its finish instead. The engine then starts a new
// message by itself.
module sha1_stream_hasher_core (
  input logic clk,
  input logic rst,
  sha1_req_if.sink   req,
  sha1_rsp_if.source rsp
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_RUN, S_FOLD, S_OUT
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic        corrupted;
  logic [31:0] h [DigestWords];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [3:0]  pad_word;
  logic        final_pass;    // compression is the last one of the finish
  logic        two_blocks;    // padding needs an extra block
  logic [2:0]  out_idx;
  logic [23:0] part;          // bytes of the word being filled

  // block memory: 16 message words
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  sha1_ram #(.Width(32), .Depth(BlockBytes / 4)) u_wmem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // schedule window of the last 16 words, kept in registers for the xor taps
  logic [31:0] win [16];
  logic [31:0] w_cur;
  logic [31:0] w_mix;

  assign w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];

  always_comb begin
    if (rnd < 7'd16) w_cur = rdata;
    else w_cur = {w_mix[30:0], w_mix[31]};
  end

  // padding word: pad byte in the first block, length in the final one
  logic [31:0] pad_data;
  logic        pad_wr;
  always_comb begin
    pad_data = 32'h0;
    if (pad_word == fill[5:2] && !(final_pass && two_blocks)) begin
      unique case (fill[1:0])
        2'd0: pad_data = {PadByte, 24'h0};
        2'd1: pad_data = {part[23:16], PadByte, 16'h0};
        2'd2: pad_data = {part[23:8], PadByte, 8'h0};
        default: pad_data = {part, PadByte};
      endcase
    end
    if (final_pass) begin
      if (pad_word == 4'd14) pad_data = pad_data | bit_length[63:32];
      if (pad_word == 4'd15) pad_data = pad_data | bit_length[31:0];
    end
  end

  // message words below the pad byte are kept, except in the spill block
  assign pad_wr = (pad_word >= fill[5:2]) || (final_pass && two_blocks);

  logic [63:0] len_plus;
  assign len_plus = bit_length + 64'd8;

  assign req.ready = (state == S_IDLE);
  // read one round ahead to cover the memory latency
  assign raddr = (state == S_RUN) ? rnd[3:0] + 4'd1 : 4'd0;
  assign we = (state == S_IDLE && req.valid && !req.data.req_type && !corrupted
               && fill[1:0] == 2'd3) || (state == S_PAD && pad_wr);
  assign waddr = (state == S_PAD) ? pad_word : fill[5:2];
  assign wdata = (state == S_PAD) ? pad_data : {part, req.data.data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      bit_length <= '0;
      corrupted <= 1'b0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      rsp.valid <= 1'b0;
      rnd <= '0;
      pad_word <= '0;
      final_pass <= 1'b0;
      two_blocks <= 1'b0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (!req.data.req_type) begin
              if (!corrupted) begin
                unique case (fill[1:0])
                  2'd0: part[23:16] <= req.data.data_byte;
                  2'd1: part[15:8] <= req.data.data_byte;
                  2'd2: part[7:0] <= req.data.data_byte;
                  default: ;
                endcase
                fill <= fill + 6'd1;
                bit_length <= len_plus;
                if (len_plus == 64'd0) corrupted <= 1'b1;
                if (fill == 6'd63) begin
                  state <= S_RUN; rnd <= '0; final_pass <= 1'b0; two_blocks <= 1'b0;
                  a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
                end
              end
            end else if (corrupted) begin
              rsp.data <= '{digest_word: 32'h0, word_index: 3'd0, last_word: 1'b1,
                            error: 1'b1};
              rsp.valid <= 1'b1;
              out_idx <= 3'd4;
              state <= S_OUT;
            end else begin
              two_blocks <= (fill >= 6'(LenPos));
              final_pass <= (fill < 6'(LenPos));
              pad_word <= '0;
              state <= S_PAD;
            end
          end
        end
        // padding words, one per cycle, into the block memory
        S_PAD: begin
          pad_word <= pad_word + 4'd1;
          if (pad_word == 4'd15) begin
            state <= S_RUN; rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        // one round per cycle
        S_RUN: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= w_cur;
          a <= {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + w_cur + round_k(rnd);
          b <= a; c <= {b[1:0], b[31:2]}; d <= c; e <= d;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_FOLD;
        end
        S_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (final_pass) begin
            out_idx <= 3'd0;
            rsp.valid <= 1'b1;
            rsp.data <= '{digest_word: h[0] + a, word_index: 3'd0, last_word: 1'b0,
                          error: 1'b0};
            state <= S_OUT;
          end else if (two_blocks) begin
            final_pass <= 1'b1; pad_word <= '0; state <= S_PAD;
          end else begin
            fill <= '0;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            if (out_idx == 3'd4) begin
              rsp.valid <= 1'b0;
              fill <= '0; bit_length <= '0; corrupted <= 1'b0;
              h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
              rsp.data <= '{digest_word: h[out_idx + 3'd1], word_index: out_idx + 3'd1,
                            last_word: (out_idx == 3'd3), error: 1'b0};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
